FILE: design/mexp_pkg.sv
// Shared widths, reset constant and controller state type for the modular exponentiator.
`default_nettype none

package mexp_pkg;

  localparam int MOD_BITS = 30;
  localparam int EXP_BITS = 64;
  localparam int MOD_CW   = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;
  localparam int EXP_CW   = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  typedef logic [MOD_BITS-1:0] mod_t;
  typedef logic [EXP_BITS-1:0] exp_t;

  localparam mod_t MODULUS_RESET = MOD_BITS'(1000000007);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MULT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: design/mexp_if.sv
// Valid/ready channel interfaces for operands and results of the modular exponentiator.
`default_nettype none

interface mexp_in_if;
  import mexp_pkg::*;

  logic valid;
  logic ready;
  mod_t base;
  exp_t exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;

  logic valid;
  logic ready;
  mod_t power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

`default_nettype wire

FILE: design/modular_exponentiation_top.sv
// Top level: bit-serial modular exponentiator, base to the exponent mod a configured modulus.
//
// Channels: operand (base, exponent) in, result (power) out, both valid/ready; a
// transaction completes on a rising clk edge with valid and ready high. The modulus
// register is written through cfg_we / cfg_data; the user must write it only while
// the block is idle: the block itself does not enforce this. One operand is
// processed at a time; operand.ready is high only when idle. Steps per transaction:
//   the accept, then restoring reduction of the base, one quotient bit a cycle.
//   Then one product pass per exponent bit; each pass
//     runs the multiply and the square side by side, one multiplier bit a cycle,
//     through an accumulate and a doubling modular adder for each product.
//   Then the result load. When the modulus is below 2, the accept is followed
//   directly by the result load (result 0).
// The result sits in an output register; if the receiver stalls, the finished
// value waits in the done state until the register frees up, so the next
// operand is accepted while a result still waits to be taken.
// Reset (rst, synchronous) returns to idle, drops result.valid and sets the
// modulus to 1000000007.
`default_nettype none

module modular_exponentiation_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mexp_pkg::MOD_BITS-1:0] cfg_data,
  mexp_in_if.sink                   operand,
  mexp_out_if.source                result
);
  import mexp_pkg::*;

  state_t            state, state_next;
  mod_t              modulus;
  mod_t              rem, bsh;
  mod_t              acc, xa, pa, xs, ps, ysh;
  exp_t              esh;
  logic [MOD_CW-1:0] bit_cnt;
  logic [EXP_CW-1:0] exp_cnt;
  logic              rvalid;
  mod_t              rpower;
  logic              out_load;

  logic [MOD_BITS:0] rem_sh;
  mod_t              rem_next;
  mod_t              pa_next, xa_next, ps_next, xs_next, acc_new;
  logic              bit_last, exp_last, accept;

  function automatic mod_t mod_add(mod_t a, mod_t b, mod_t m);
    logic [MOD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MOD_BITS-1:0];
  endfunction

  assign accept   = operand.valid && operand.ready;
  assign bit_last = (bit_cnt == MOD_CW'(MOD_BITS - 1));
  assign exp_last = (exp_cnt == EXP_CW'(EXP_BITS - 1));

  always_comb begin
    rem_sh   = {rem, bsh[MOD_BITS-1]};
    rem_next = rem_sh[MOD_BITS-1:0];
    if (rem_sh >= {1'b0, modulus}) begin
      rem_next = MOD_BITS'(rem_sh - {1'b0, modulus});
    end
  end

  // Both products scan the bits of the current square
  assign pa_next = ysh[0] ? mod_add(pa, xa, modulus) : pa;
  assign xa_next = mod_add(xa, xa, modulus);
  assign ps_next = ysh[0] ? mod_add(ps, xs, modulus) : ps;
  assign xs_next = mod_add(xs, xs, modulus);
  assign acc_new = esh[0] ? pa_next : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    operand.ready = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        operand.ready = 1'b1;
        if (operand.valid) begin
          state_next = (modulus < MOD_BITS'(2)) ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (bit_last) state_next = ST_MULT;
      end
      ST_MULT: begin
        if (bit_last && exp_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rvalid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          bsh     <= operand.base;
          esh     <= operand.exponent;
          rem     <= '0;
          acc     <= '0;
          bit_cnt <= '0;
        end
      end
      ST_REDUCE: begin
        rem     <= rem_next;
        bsh     <= bsh << 1;
        bit_cnt <= bit_last ? '0 : bit_cnt + MOD_CW'(1);
        if (bit_last) begin
          acc     <= MOD_BITS'(1);
          xa      <= MOD_BITS'(1);
          pa      <= '0;
          xs      <= rem_next;
          ysh     <= rem_next;
          ps      <= '0;
          exp_cnt <= '0;
        end
      end
      ST_MULT: begin
        if (bit_last) begin
          // Close the pass: commit the product, start on the next exponent bit
          acc     <= acc_new;
          xa      <= acc_new;
          pa      <= '0;
          xs      <= ps_next;
          ysh     <= ps_next;
          ps      <= '0;
          esh     <= esh >> 1;
          exp_cnt <= exp_cnt + EXP_CW'(1);
          bit_cnt <= '0;
        end else begin
          pa      <= pa_next;
          xa      <= xa_next;
          ps      <= ps_next;
          xs      <= xs_next;
          ysh     <= ysh >> 1;
          bit_cnt <= bit_cnt + MOD_CW'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
      rvalid  <= 1'b0;
    end else begin
      if (cfg_we) modulus <= cfg_data;
      if (out_load) begin
        rvalid <= 1'b1;
      end else if (result.ready) begin
        rvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) rpower <= acc;
  end

  assign result.valid = rvalid;
  assign result.power = rpower;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted transaction did not start processing");

  a_last_pass_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULT && bit_last && exp_last) |=> state == ST_DONE)
    else $error("final product pass did not reach done");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!rvalid || result.ready)) |=> (rvalid && state == ST_IDLE))
    else $error("free output register not loaded from done");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rvalid) |-> $past(state) == ST_DONE)
    else $error("result raised outside done state");

endmodule

`default_nettype wire
